@@ rtl/kect_pkg.sv @@
package kect_pkg;

  localparam int unsigned KeyW  = 10;
  localparam int unsigned CodeW = 10;
  localparam int unsigned ValW  = 2;
  localparam int unsigned ThrW  = 4;

  localparam int unsigned BaseDepth = 128;
  localparam int unsigned ModDepth  = 87;

  localparam logic [ValW-1:0] KeyRelease = 2'd0;

  localparam logic [KeyW-1:0] KeyUp     = 10'd103;
  localparam logic [KeyW-1:0] KeyDown   = 10'd108;
  localparam logic [KeyW-1:0] KeyLeft   = 10'd105;
  localparam logic [KeyW-1:0] KeyRight  = 10'd106;
  localparam logic [KeyW-1:0] KeyOk     = 10'h160;
  localparam logic [KeyW-1:0] KeyRed    = 10'h18E;
  localparam logic [KeyW-1:0] KeyGreen  = 10'h18F;
  localparam logic [KeyW-1:0] KeyYellow = 10'h190;
  localparam logic [KeyW-1:0] KeyBlue   = 10'h191;
  localparam logic [KeyW-1:0] KeyHelp   = 10'd138;
  localparam logic [KeyW-1:0] KeySetup  = 10'd141;
  localparam logic [KeyW-1:0] KeyHome   = 10'd102;
  localparam logic [KeyW-1:0] KeyPower  = 10'd116;
  localparam logic [KeyW-1:0] KeyAsciiLast = 10'h7F;
  localparam logic [KeyW-1:0] KeyWide   = 10'h110;
  localparam logic [KeyW-1:0] KeyModLast = 10'h56;
  localparam logic [KeyW-1:0] KeyDigitFirst = 10'd2;
  localparam logic [KeyW-1:0] KeyDigitLast  = 10'd11;

  localparam logic [CodeW-1:0] CodeUp     = 10'h193;
  localparam logic [CodeW-1:0] CodeDown   = 10'h194;
  localparam logic [CodeW-1:0] CodeLeft   = 10'h192;
  localparam logic [CodeW-1:0] CodeRight  = 10'h191;
  localparam logic [CodeW-1:0] CodeOk     = 10'h00D;
  localparam logic [CodeW-1:0] CodeRed    = 10'h1A3;
  localparam logic [CodeW-1:0] CodeGreen  = 10'h1A1;
  localparam logic [CodeW-1:0] CodeYellow = 10'h1A2;
  localparam logic [CodeW-1:0] CodeBlue   = 10'h1A4;
  localparam logic [CodeW-1:0] CodeHelp   = 10'h1B3;
  localparam logic [CodeW-1:0] CodeSetup  = 10'h1B4;
  localparam logic [CodeW-1:0] CodeHome   = 10'h1B1;
  localparam logic [CodeW-1:0] CodePower  = 10'h01C;
  localparam logic [CodeW-1:0] CodeWide   = 10'h1CE;
  localparam logic [CodeW-1:0] CodeShift  = 10'h00E;
  localparam logic [CodeW-1:0] CodeAltGr  = 10'h012;
  localparam logic [CodeW-1:0] CodeAlt    = 10'h00F;
  localparam logic [CodeW-1:0] CodeAltDigit = 10'h200;

  localparam logic [CodeW-1:0] BASE_MAP [BaseDepth] = '{
    10'h000,10'h1B1,10'h031,10'h032,10'h033,10'h034,10'h035,10'h036,
    10'h037,10'h038,10'h039,10'h030,10'h0DF,10'h0B4,10'h008,10'h009,
    10'h071,10'h077,10'h065,10'h072,10'h074,10'h07A,10'h075,10'h069,
    10'h06F,10'h070,10'h0FC,10'h02B,10'h00D,10'h000,10'h061,10'h073,
    10'h064,10'h066,10'h067,10'h068,10'h06A,10'h06B,10'h06C,10'h0F6,
    10'h0E4,10'h05E,10'h00E,10'h023,10'h079,10'h078,10'h063,10'h076,
    10'h062,10'h06E,10'h06D,10'h02C,10'h02E,10'h02D,10'h00E,10'h000,
    10'h00F,10'h020,10'h1CD,10'h1A3,10'h1A1,10'h1A2,10'h1A4,10'h1C5,
    10'h1C6,10'h1C7,10'h1C8,10'h1C9,10'h1CA,10'h1B4,10'h000,10'h000,
    10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,
    10'h000,10'h01C,10'h000,10'h000,10'h000,10'h000,10'h03C,10'h00D,
    10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,
    10'h000,10'h000,10'h000,10'h000,10'h012,10'h000,10'h1B1,10'h193,
    10'h195,10'h192,10'h191,10'h013,10'h194,10'h196,10'h010,10'h011,
    10'h000,10'h1B2,10'h196,10'h195,10'h01C,10'h000,10'h000,10'h1B3,
    10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000
  };

  localparam logic [CodeW-1:0] SHIFT_MAP [ModDepth] = '{
    10'h000,10'h1B1,10'h021,10'h022,10'h0A7,10'h024,10'h025,10'h026,
    10'h02F,10'h028,10'h029,10'h03D,10'h03F,10'h060,10'h008,10'h009,
    10'h051,10'h057,10'h045,10'h052,10'h054,10'h05A,10'h055,10'h049,
    10'h04F,10'h050,10'h0DC,10'h02A,10'h1CC,10'h000,10'h041,10'h053,
    10'h044,10'h046,10'h047,10'h048,10'h04A,10'h04B,10'h04C,10'h0D6,
    10'h0C4,10'h0B0,10'h00E,10'h027,10'h059,10'h058,10'h043,10'h056,
    10'h042,10'h04E,10'h04D,10'h03B,10'h03A,10'h05F,10'h00E,10'h000,
    10'h00F,10'h020,10'h1CD,10'h1A3,10'h1A1,10'h1A2,10'h1A4,10'h1C5,
    10'h1C6,10'h1C7,10'h1C8,10'h1C9,10'h1CA,10'h1B4,10'h000,10'h000,
    10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,
    10'h000,10'h01C,10'h000,10'h000,10'h000,10'h000,10'h03E
  };

  localparam logic [CodeW-1:0] ALTGR_MAP [ModDepth] = '{
    10'h000,10'h1B1,10'h000,10'h0B2,10'h0B3,10'h000,10'h000,10'h000,
    10'h07B,10'h05B,10'h05D,10'h07D,10'h05C,10'h000,10'h000,10'h000,
    10'h040,10'h000,10'h02E,10'h000,10'h000,10'h000,10'h000,10'h000,
    10'h000,10'h000,10'h000,10'h07E,10'h1CC,10'h000,10'h000,10'h000,
    10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,
    10'h000,10'h000,10'h00E,10'h000,10'h000,10'h000,10'h000,10'h000,
    10'h000,10'h000,10'h0B5,10'h000,10'h000,10'h000,10'h00E,10'h000,
    10'h00F,10'h020,10'h1CD,10'h1A3,10'h1A1,10'h1A2,10'h1A4,10'h1C5,
    10'h1C6,10'h1C7,10'h1C8,10'h1C9,10'h1CA,10'h1B4,10'h000,10'h000,
    10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,
    10'h000,10'h01C,10'h000,10'h000,10'h000,10'h000,10'h07C
  };

endpackage

@@ rtl/kect_translate.sv @@
module kect_translate #(
  parameter int unsigned TableDepth = 128
) (
  input  logic [kect_pkg::KeyW-1:0]  key_i,
  input  logic [kect_pkg::CodeW-1:0] prev_code_i,
  output logic [kect_pkg::CodeW-1:0] code_o
);

  logic [kect_pkg::CodeW-1:0] table_code;
  logic [kect_pkg::CodeW-1:0] mod_code;
  logic                       fixed_hit;
  logic [kect_pkg::CodeW-1:0] fixed_code;
  logic                       in_mod_range;
  logic                       in_digit_row;
  logic [kect_pkg::KeyW-1:0]  digit;

  always_comb begin
    fixed_hit  = 1'b1;
    fixed_code = '0;
    case (key_i)
      kect_pkg::KeyUp:     fixed_code = kect_pkg::CodeUp;
      kect_pkg::KeyDown:   fixed_code = kect_pkg::CodeDown;
      kect_pkg::KeyLeft:   fixed_code = kect_pkg::CodeLeft;
      kect_pkg::KeyRight:  fixed_code = kect_pkg::CodeRight;
      kect_pkg::KeyOk:     fixed_code = kect_pkg::CodeOk;
      kect_pkg::KeyRed:    fixed_code = kect_pkg::CodeRed;
      kect_pkg::KeyGreen:  fixed_code = kect_pkg::CodeGreen;
      kect_pkg::KeyYellow: fixed_code = kect_pkg::CodeYellow;
      kect_pkg::KeyBlue:   fixed_code = kect_pkg::CodeBlue;
      kect_pkg::KeyHelp:   fixed_code = kect_pkg::CodeHelp;
      kect_pkg::KeySetup:  fixed_code = kect_pkg::CodeSetup;
      kect_pkg::KeyHome:   fixed_code = kect_pkg::CodeHome;
      kect_pkg::KeyPower:  fixed_code = kect_pkg::CodePower;
      default:             fixed_hit  = 1'b0;
    endcase
  end

  always_comb begin
    if (key_i > kect_pkg::KeyAsciiLast) begin
      table_code = (key_i == kect_pkg::KeyWide) ? kect_pkg::CodeWide : '0;
    end else if (32'(key_i) < TableDepth) begin
      table_code = kect_pkg::BASE_MAP[key_i[6:0]];
    end else begin
      table_code = '0;
    end
  end

  assign in_mod_range = (key_i <= kect_pkg::KeyModLast);
  assign in_digit_row = (key_i >= kect_pkg::KeyDigitFirst) &&
                        (key_i <= kect_pkg::KeyDigitLast);
  assign digit        = key_i - kect_pkg::KeyW'(1);

  always_comb begin
    mod_code = table_code;
    if (prev_code_i == kect_pkg::CodeShift) begin
      if (in_mod_range) begin
        mod_code = kect_pkg::SHIFT_MAP[key_i[6:0]];
      end
    end else if (prev_code_i == kect_pkg::CodeAltGr) begin
      if (in_mod_range) begin
        mod_code = kect_pkg::ALTGR_MAP[key_i[6:0]];
      end
    end else if (prev_code_i == kect_pkg::CodeAlt) begin
      if (in_digit_row) begin
        mod_code = kect_pkg::CodeAltDigit | digit;
      end
    end
  end

  assign code_o = fixed_hit ? fixed_code : mod_code;

endmodule

@@ rtl/key_event_code_translator.sv @@
// Key event to remote code translator.
// Input stream (s_axis): one key event per transaction, tdata carries the key
// number in [9:0] and the event value in [11:10] (0 release, 1 press, 2 repeat).
// Output stream (m_axis): one remote code per emitted event in tdata[9:0].
// Config channel (cfg_*): writes the 4-bit repeat threshold; always ready,
// write only while no events are in flight.
// An event is captured in the input register, translated by the
// lookup logic, and registered in the output register that drives m_axis.
// Throughput: one event per cycle while m_axis is not stalled; the lookup and
// repeat compare sit between the input register and the output register.
// Releases and swallowed repeats produce no output transaction.
// When the receiver stalls, the output register holds its code and the input
// register may still take one more event; s_axis_tready_o drops only while
// both are full and the held event would emit a code.
// Reset clears the valid flags of both registers, the remembered key, the previous code and the
// repeat count, and sets the threshold to 3.
module key_event_code_translator #(
  parameter int unsigned TableDepth = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [9:0] key_number, [11:10] key_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [9:0] remote_code
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i        // [3:0] repeat_threshold
);

  logic                        in_valid_q;
  logic [kect_pkg::KeyW-1:0]   in_key_q;
  logic [kect_pkg::ValW-1:0]   in_val_q;
  logic                        out_valid_q;
  logic [kect_pkg::CodeW-1:0]  out_code_q;
  logic [kect_pkg::ThrW-1:0]   thr_q;
  logic [kect_pkg::KeyW-1:0]   last_key_q;
  logic [kect_pkg::CodeW-1:0]  prev_code_q;
  logic [kect_pkg::ThrW-1:0]   count_q;

  logic [kect_pkg::CodeW-1:0]  code;
  logic                        is_release;
  logic                        same_key;
  logic                        swallow;
  logic                        emit;
  logic                        advance;
  logic                        s_take;

  kect_translate #(
    .TableDepth(TableDepth)
  ) u_translate (
    .key_i      (in_key_q),
    .prev_code_i(prev_code_q),
    .code_o     (code)
  );

  assign is_release = (in_val_q == kect_pkg::KeyRelease);
  assign same_key   = (in_key_q == last_key_q);
  assign swallow    = !is_release && same_key && (count_q < thr_q);
  assign emit       = !is_release && !swallow;
  assign advance    = in_valid_q && (!emit || !out_valid_q || m_axis_tready_i);

  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_code_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 4'd3;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_key_q <= s_axis_tdata_i[9:0];
      in_val_q <= s_axis_tdata_i[11:10];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_code_q <= code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q  <= '0;
      prev_code_q <= '0;
      count_q     <= '0;
    end else if (advance) begin
      if (is_release) begin
        last_key_q  <= '0;
        prev_code_q <= '0;
      end else if (swallow) begin
        count_q <= count_q + kect_pkg::ThrW'(1);
      end else begin
        if (!same_key) begin
          count_q <= '0;
        end
        last_key_q  <= in_key_q;
        prev_code_q <= code;
      end
    end
  end

endmodule

@@ rtl/kect_checker.sv @@
module kect_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction changed while stalled");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:10] == 6'd0))
    else $error("remote code exceeds 10 bits");

  // input backpressure only comes from a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind key_event_code_translator kect_checker u_kect_checker (.*);
